### rtl/rle_delta_tile_layer_decoder_assert.svh
// Assertion macros for the tile layer decoder.
// Define ASSERT_OFF to compile the checks out.
`ifndef RLE_DELTA_TILE_LAYER_DECODER_ASSERT_SVH
`define RLE_DELTA_TILE_LAYER_DECODER_ASSERT_SVH

`ifndef ASSERT_OFF

// cond must hold at every clock edge out of reset
`define RDTL_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("rdtl assertion failed");

// cons must hold at every edge where ante holds
`define RDTL_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rdtl implication failed");

`else

`define RDTL_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define RDTL_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`endif

`endif

### rtl/rdtl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rdtl_pkg;

    localparam int TILE_W    = 8;   // stored tile byte
    localparam int LIT_W     = 7;   // literal and running sum
    localparam int ADDR_W    = 12;  // tile address
    localparam int ALU_W     = 13;  // shared adder, holds a count up to 4096
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 7;   // widest register

    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_PUSH  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_RUN_FILLS_ZERO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACC_ENABLE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACC_SEED       = 2'd2;

    localparam logic [LIT_W-1:0] SEED_RESET = 7'd64;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic [ALU_W-1:0] lim;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             a_lt;
    } t_alu_rsp;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [TILE_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

`default_nettype wire

### rtl/rdtl_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module rdtl_alu
    import rdtl_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    // one adder and one bound compare, shared by the sequencer steps
    always_comb begin
        o_rsp.sum  = i_req.a + i_req.b;
        o_rsp.a_lt = (i_req.a < i_req.lim);
    end

endmodule

`default_nettype wire

### rtl/rdtl_store.sv
`timescale 1ns / 1ps
`default_nettype none

module rdtl_store
    import rdtl_pkg::*;
#(
    parameter int DEPTH = 2304
) (
    input  logic              i_clk,
    input  t_mem_req          i_req,
    output logic [TILE_W-1:0] o_rdata
);

    localparam int AW = $clog2(DEPTH);

    logic [TILE_W-1:0] r_mem [DEPTH];
    logic [TILE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr[AW-1:0]] <= i_req.wdata;
        end
    end

    // registered read, holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr[AW-1:0]];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/rle_delta_tile_layer_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel    Direction  Handshake           Payload
// input      in         i_valid / o_stall   i_op, i_code_byte, i_tile_index
// result     out        o_valid / i_stall   o_tile_value, o_layer_complete, o_overflow
// config     in         i_cfg_we            i_cfg_index, i_cfg_wdata
//
// A start is done in the idle state; a literal is written and then checked; a
// run writes its tiles and then is checked; a read waits for the result register.
// The item that fills the layer adds the running-sum pass: per tile one read,
// one add and write, and one address step, all on the single adder.
// Reset is synchronous and active low; the tile store is not cleared.
// A stalled result holds in the output register; a read behind it waits there.

module rle_delta_tile_layer_decoder
    import rdtl_pkg::*;
#(
    parameter int GRID_SIDE = 48,
    parameter int TILES     = 2304
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input items
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [OP_W-1:0]      i_op,
    input  logic [TILE_W-1:0]    i_code_byte,
    input  logic [ADDR_W-1:0]    i_tile_index,
    // result items
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [TILE_W-1:0]    o_tile_value,
    output logic                 o_layer_complete,
    output logic                 o_overflow,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

`include "rle_delta_tile_layer_decoder_assert.svh"

    localparam int CW = $clog2(TILES + 1);               // fill count
    localparam int PW = $clog2(GRID_SIDE * GRID_SIDE);   // pass address
    localparam int RW = $clog2(GRID_SIDE);               // row and column

    localparam logic [ALU_W-1:0] TILES_A = ALU_W'(TILES);
    localparam logic [ALU_W-1:0] SIDE_A  = ALU_W'(GRID_SIDE);
    localparam logic [RW-1:0]    LAST_RC = RW'(GRID_SIDE - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RUN   = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_PRD   = 3'd3;
    localparam logic [2:0] S_PWR   = 3'd4;
    localparam logic [2:0] S_PADV  = 3'd5;
    localparam logic [2:0] S_RRESP = 3'd6;

    // control
    logic [2:0]        r_state,    n_state;
    logic [CW-1:0]     r_fill,     n_fill;
    logic [LIT_W-1:0]  r_last,     n_last;
    logic              r_complete, n_complete;
    logic              r_overflow, n_overflow;
    logic              r_out_valid, n_out_valid;
    logic              r_zero_run;
    logic              r_acc_en;
    logic [LIT_W-1:0]  r_seed;
    // payload
    logic [LIT_W-1:0]  r_run_left, n_run_left;
    logic [LIT_W-1:0]  r_run_val,  n_run_val;
    logic [LIT_W-1:0]  r_sum,      n_sum;
    logic [PW-1:0]     r_addr,     n_addr;
    logic [RW-1:0]     r_row,      n_row;
    logic [RW-1:0]     r_col,      n_col;
    logic              r_rd_oob,   n_rd_oob;
    logic [TILE_W-1:0] r_out_value, n_out_value;
    logic              r_out_cmp,  n_out_cmp;
    logic              r_out_ovf,  n_out_ovf;

    t_alu_req          alu_req;
    t_alu_rsp          alu_rsp;
    t_mem_req          mem_req;
    logic [TILE_W-1:0] mem_rdata;
    logic              in_acc;
    logic              out_free;

    rdtl_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    rdtl_store #(
        .DEPTH (TILES)
    ) u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_last      = r_last;
        n_complete  = r_complete;
        n_overflow  = r_overflow;
        n_run_left  = r_run_left;
        n_run_val   = r_run_val;
        n_sum       = r_sum;
        n_addr      = r_addr;
        n_row       = r_row;
        n_col       = r_col;
        n_rd_oob    = r_rd_oob;
        n_out_value = r_out_value;
        n_out_cmp   = r_out_cmp;
        n_out_ovf   = r_out_ovf;
        // drop the result once taken
        n_out_valid = r_out_valid && i_stall;

        // shared adder defaults: fill + 1, bounded by the layer size
        alu_req.a   = ALU_W'(r_fill);
        alu_req.b   = ALU_W'(1);
        alu_req.lim = TILES_A;

        mem_req.we    = 1'b0;
        mem_req.waddr = ADDR_W'(r_fill);
        mem_req.wdata = TILE_W'(r_run_val);
        mem_req.re    = 1'b0;
        mem_req.raddr = i_tile_index;

        unique case (r_state)
            S_IDLE: begin
                if (i_op == OP_READ) begin
                    alu_req.a = ALU_W'(i_tile_index);
                end
                if (in_acc) begin
                    unique case (i_op)
                        OP_START: begin
                            n_fill     = '0;
                            n_last     = '0;
                            n_complete = 1'b0;
                            n_overflow = 1'b0;
                        end
                        OP_PUSH: begin
                            // a full layer ignores further bytes
                            if (alu_rsp.a_lt) begin
                                if (!i_code_byte[TILE_W-1]) begin
                                    mem_req.we    = 1'b1;
                                    mem_req.wdata = i_code_byte;
                                    n_last        = i_code_byte[LIT_W-1:0];
                                    n_fill        = alu_rsp.sum[CW-1:0];
                                    n_state       = S_CHECK;
                                end else begin
                                    n_run_left = i_code_byte[LIT_W-1:0];
                                    n_run_val  = r_zero_run ? '0 : r_last;
                                    n_state    = S_RUN;
                                end
                            end
                        end
                        OP_READ: begin
                            n_rd_oob = !alu_rsp.a_lt;
                            mem_req.re = alu_rsp.a_lt;
                            n_state  = S_RRESP;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_RUN: begin
                // one run tile a cycle; cut the run at the end of the layer
                if (r_run_left == '0) begin
                    n_state = S_CHECK;
                end else if (!alu_rsp.a_lt) begin
                    n_overflow = 1'b1;
                    n_state    = S_CHECK;
                end else begin
                    mem_req.we = 1'b1;
                    n_fill     = alu_rsp.sum[CW-1:0];
                    n_run_left = r_run_left - 1'b1;
                end
            end

            S_CHECK: begin
                n_state = S_IDLE;
                if (!alu_rsp.a_lt && !r_complete) begin
                    if (r_acc_en) begin
                        n_sum   = r_seed;
                        n_addr  = '0;
                        n_row   = '0;
                        n_col   = '0;
                        n_state = S_PRD;
                    end else begin
                        n_complete = 1'b1;
                    end
                end
            end

            S_PRD: begin
                // skip addresses beyond the store
                alu_req.a     = ALU_W'(r_addr);
                alu_req.b     = '0;
                mem_req.re    = alu_rsp.a_lt;
                mem_req.raddr = ADDR_W'(r_addr);
                n_state       = alu_rsp.a_lt ? S_PWR : S_PADV;
            end

            S_PWR: begin
                alu_req.a     = ALU_W'(mem_rdata);
                alu_req.b     = ALU_W'(r_sum);
                n_sum         = alu_rsp.sum[LIT_W-1:0];
                mem_req.we    = 1'b1;
                mem_req.waddr = ADDR_W'(r_addr);
                mem_req.wdata = {alu_rsp.sum[LIT_W-1:0], 1'b0};
                n_state       = S_PADV;
            end

            S_PADV: begin
                // walk down a row's columns by stepping the address by the side
                alu_req.a = ALU_W'(r_addr);
                alu_req.b = SIDE_A;
                n_state   = S_PRD;
                if (r_col == LAST_RC) begin
                    if (r_row == LAST_RC) begin
                        n_complete = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        n_row  = r_row + 1'b1;
                        n_col  = '0;
                        n_addr = PW'(r_row + 1'b1);
                    end
                end else begin
                    n_col  = r_col + 1'b1;
                    n_addr = alu_rsp.sum[PW-1:0];
                end
            end

            S_RRESP: begin
                // hold until the result register is free
                if (out_free) begin
                    n_out_value = r_rd_oob ? '0 : mem_rdata;
                    n_out_cmp   = r_complete;
                    n_out_ovf   = r_overflow;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_last      <= '0;
            r_complete  <= 1'b0;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
            r_zero_run  <= 1'b0;
            r_acc_en    <= 1'b1;
            r_seed      <= SEED_RESET;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_last      <= n_last;
            r_complete  <= n_complete;
            r_overflow  <= n_overflow;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_RUN_FILLS_ZERO: r_zero_run <= i_cfg_wdata[0];
                    CFG_ACC_ENABLE:     r_acc_en   <= i_cfg_wdata[0];
                    CFG_ACC_SEED:       r_seed     <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_run_left  <= n_run_left;
        r_run_val   <= n_run_val;
        r_sum       <= n_sum;
        r_addr      <= n_addr;
        r_row       <= n_row;
        r_col       <= n_col;
        r_rd_oob    <= n_rd_oob;
        r_out_value <= n_out_value;
        r_out_cmp   <= n_out_cmp;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_valid          = r_out_valid;
    assign o_tile_value     = r_out_value;
    assign o_layer_complete = r_out_cmp;
    assign o_overflow       = r_out_ovf;

    `RDTL_ASSERT_ALWAYS(a_fill_bound, i_clk, i_rst_n, r_fill <= CW'(TILES))
    `RDTL_ASSERT_IMPLY(a_cmp_full, i_clk, i_rst_n, r_complete, r_fill == CW'(TILES))
    `RDTL_ASSERT_IMPLY(a_ovf_full, i_clk, i_rst_n, r_overflow, r_fill == CW'(TILES))
    `RDTL_ASSERT_IMPLY(a_wr_range, i_clk, i_rst_n, mem_req.we, ALU_W'(mem_req.waddr) < TILES_A)

endmodule

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import rdtl_pkg::*;

    localparam int GRID  = 48;
    localparam int TILES = GRID * GRID;

    // op 3 has no meaning in the block and must be swallowed without a result
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Worst case the block spends on one item: the running-sum sweep after the
    // layer fills, per tile a read, add and write, address step on one adder.
    localparam int SWEEP_CYCLES  = 3 * TILES + 1;
    localparam int SETTLE_CYCLES = SWEEP_CYCLES + 64;
    localparam int HOLD_LEN      = 300;
    localparam int GAP_PCT       = 38;
    localparam int MAX_REPORTS   = 10;
    // Longest correct stretch without any handshake: a settle pause, the sweep
    // and a full receiver hold-off back to back stay well below this.
    localparam int QUIET_LIMIT   = 40000;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [TILE_W-1:0] code;
        logic [ADDR_W-1:0] idx;
    } t_tile_cmd;

    typedef struct packed {
        logic [TILE_W-1:0] value;
        logic              complete;
        logic              ovf;
    } t_tile_read;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_valid      = 1'b0;
    logic                 o_stall;
    logic [OP_W-1:0]      i_op         = '0;
    logic [TILE_W-1:0]    i_code_byte  = '0;
    logic [ADDR_W-1:0]    i_tile_index = '0;
    logic                 o_valid;
    logic                 i_stall      = 1'b0;
    logic [TILE_W-1:0]    o_tile_value;
    logic                 o_layer_complete;
    logic                 o_overflow;
    logic                 i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index  = '0;
    logic [CFG_W-1:0]     i_cfg_wdata  = '0;

    rle_delta_tile_layer_decoder #(
        .GRID_SIDE(GRID),
        .TILES    (TILES)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_op            (i_op),
        .i_code_byte     (i_code_byte),
        .i_tile_index    (i_tile_index),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_tile_value    (o_tile_value),
        .o_layer_complete(o_layer_complete),
        .o_overflow      (o_overflow),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin : clock_gen
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Layer predictor: own copy of the tile store, fill pointer, flags and
    // register settings, advanced once per accepted item.
    // ------------------------------------------------------------------
    logic [TILE_W-1:0] layer_tiles [TILES];
    int                layer_fill    = 0;
    logic [LIT_W-1:0]  layer_lit     = '0;
    logic              layer_done    = 1'b0;
    logic              layer_ovf     = 1'b0;
    logic              set_zero_runs = 1'b0;
    logic              set_acc_on    = 1'b1;
    logic [LIT_W-1:0]  set_seed      = SEED_RESET;

    t_tile_read read_expect_q [$];

    int n_layers     = 0;
    int n_ovf_layers = 0;

    // Column-order running sum: walk rows, and columns within a row; keep the
    // sum modulo 128 and store twice the sum back.
    function automatic void run_sum_pass();
        logic [LIT_W-1:0] acc;
        int               a;
        acc = set_seed;
        for (int r = 0; r < GRID; r++) begin
            for (int c = 0; c < GRID; c++) begin
                a = c * GRID + r;
                if (a < TILES) begin
                    acc = acc + layer_tiles[a][LIT_W-1:0];
                    layer_tiles[a] = {acc, 1'b0};
                end
            end
        end
    endfunction

    function automatic void apply_cmd(input t_tile_cmd cmd);
        int                n;
        logic [TILE_W-1:0] v;
        t_tile_read        rd;
        case (cmd.op)
            OP_START: begin
                // clear pointer and flags, keep the stored tiles
                layer_fill = 0;
                layer_lit  = '0;
                layer_done = 1'b0;
                layer_ovf  = 1'b0;
            end
            OP_PUSH: begin
                if (layer_fill < TILES) begin
                    if (!cmd.code[7]) begin
                        // literal: store it and remember it for later runs
                        layer_tiles[layer_fill] = cmd.code;
                        layer_fill++;
                        layer_lit = cmd.code[LIT_W-1:0];
                    end else begin
                        n = int'(cmd.code[LIT_W-1:0]);
                        v = set_zero_runs ? '0 : {1'b0, layer_lit};
                        // cut the run at the last tile and flag it
                        if (n > TILES - layer_fill) begin
                            layer_ovf = 1'b1;
                            n = TILES - layer_fill;
                        end
                        repeat (n) begin
                            layer_tiles[layer_fill] = v;
                            layer_fill++;
                        end
                    end
                    if (layer_fill >= TILES && !layer_done) begin
                        if (set_acc_on)
                            run_sum_pass();
                        layer_done = 1'b1;
                        n_layers++;
                        if (layer_ovf)
                            n_ovf_layers++;
                    end
                end
            end
            OP_READ: begin
                rd.value    = (int'(cmd.idx) < TILES) ? layer_tiles[cmd.idx] : '0;
                rd.complete = layer_done;
                rd.ovf      = layer_ovf;
                read_expect_q.push_back(rd);
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Item source: the stimulus process fills cmd_q; a shadow fill pointer
    // keeps most reads on tiles that have been written since reset.
    // ------------------------------------------------------------------
    t_tile_cmd cmd_q [$];
    int        n_queued    = 0;
    int        n_taken     = 0;
    int        gen_fill    = 0;
    int        gen_hwm     = 0;
    int        phase_items = 0;
    int        n_settings  = 0;
    logic      no_gaps     = 1'b0;

    task automatic queue_cmd(input logic [OP_W-1:0] op, input logic [TILE_W-1:0] code,
                             input logic [ADDR_W-1:0] idx);
        t_tile_cmd cmd;
        cmd.op   = op;
        cmd.code = code;
        cmd.idx  = idx;
        cmd_q.push_back(cmd);
        n_queued++;
        case (op)
            OP_START: begin
                gen_fill = 0;
                phase_items++;
            end
            OP_PUSH: begin
                // a push into a full layer is dropped and does not count
                if (gen_fill < TILES) begin
                    phase_items++;
                    if (!code[7])
                        gen_fill++;
                    else if (gen_fill + int'(code[LIT_W-1:0]) > TILES)
                        gen_fill = TILES;
                    else
                        gen_fill = gen_fill + int'(code[LIT_W-1:0]);
                end
            end
            OP_READ: phase_items++;
            default: ;
        endcase
        if (gen_fill > gen_hwm)
            gen_hwm = gen_fill;
    endtask

    // Pick a read address: mostly written tiles, often near the fill point,
    // sometimes past the end of the store.
    function automatic logic [ADDR_W-1:0] read_addr();
        if (gen_hwm == 0 || $urandom_range(0, 9) == 0)
            return ADDR_W'($urandom_range(TILES, (1 << ADDR_W) - 1));
        if (gen_fill > 0 && $urandom_range(0, 1) == 1)
            return ADDR_W'($urandom_range(gen_fill > 16 ? gen_fill - 16 : 0, gen_fill - 1));
        return ADDR_W'($urandom_range(0, gen_hwm - 1));
    endfunction

    // One layer: start, a coded stream that fills it, reads and noise mixed in,
    // the odd abandoned layer, result reads, then pushes the layer drops.
    task automatic gen_layer();
        int pick;
        int room;
        queue_cmd(OP_START, TILE_W'($urandom), ADDR_W'($urandom));
        while (gen_fill < TILES) begin
            pick = $urandom_range(0, 99);
            room = TILES - gen_fill;
            if (pick < 2)
                queue_cmd(OP_UNUSED, TILE_W'($urandom), ADDR_W'($urandom));
            else if (pick < 3)
                queue_cmd(OP_START, TILE_W'($urandom), ADDR_W'($urandom));
            else if (pick < 20)
                queue_cmd(OP_READ, TILE_W'($urandom), read_addr());
            else if (pick < 38)
                queue_cmd(OP_PUSH, TILE_W'($urandom_range(0, 127)), ADDR_W'($urandom));
            else if (room <= 127 && $urandom_range(0, 2) == 0)
                // land exactly on the last tile, no overflow
                queue_cmd(OP_PUSH, TILE_W'(128 + room), ADDR_W'($urandom));
            else
                queue_cmd(OP_PUSH, TILE_W'($urandom_range(128, 255)), ADDR_W'($urandom));
        end
        repeat ($urandom_range(4, 12))
            queue_cmd(OP_READ, TILE_W'($urandom), read_addr());
        repeat ($urandom_range(0, 2))
            queue_cmd(OP_PUSH, TILE_W'($urandom), ADDR_W'($urandom));
    endtask

    // Hold until every item is taken and every read answered, then let a
    // possible running-sum sweep finish before touching the registers.
    task automatic wait_quiet();
        while (!(n_taken == n_queued && read_expect_q.size() == 0))
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
    endtask

    task automatic run_phase(input logic zero_runs, input logic acc_on,
                             input logic [LIT_W-1:0] seed, input int budget, input logic calm);
        set_reg(CFG_RUN_FILLS_ZERO, CFG_W'(zero_runs));
        set_reg(CFG_ACC_ENABLE, CFG_W'(acc_on));
        set_reg(CFG_ACC_SEED, seed);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        set_zero_runs = zero_runs;
        set_acc_on    = acc_on;
        set_seed      = seed;
        n_settings++;
        @(negedge i_clk);
        no_gaps     = calm;
        phase_items = 0;
        while (phase_items < budget)
            gen_layer();
        wait_quiet();
        no_gaps = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sender: update the predictor on each accepted item, then present the
    // next queued item unless this cycle is an idle one.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : sender
        t_tile_cmd cur;
        t_tile_cmd nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                cur.op   = i_op;
                cur.code = i_code_byte;
                cur.idx  = i_tile_index;
                apply_cmd(cur);
                n_taken++;
            end
            // hold a stalled item; otherwise advance or idle
            if (!i_valid || !o_stall) begin
                if (cmd_q.size() > 0 && (no_gaps || $urandom_range(0, 99) >= GAP_PCT)) begin
                    nxt = cmd_q.pop_front();
                    i_valid      <= 1'b1;
                    i_op         <= nxt.op;
                    i_code_byte  <= nxt.code;
                    i_tile_index <= nxt.idx;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: compare each read result with the oldest expectation and
    // drive the stall, with a long hold-off now and then so the result
    // register backs up into the input side.
    // ------------------------------------------------------------------
    int n_checked    = 0;
    int n_err        = 0;
    int n_holds      = 0;
    int hold_left    = 0;
    int next_hold_at = 60;

    always @(posedge i_clk) begin : receiver
        t_tile_read got;
        t_tile_read want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                got.value    = o_tile_value;
                got.complete = o_layer_complete;
                got.ovf      = o_overflow;
                if (read_expect_q.size() == 0) begin
                    if (n_err < MAX_REPORTS)
                        $display("%0t: unexpected read result value %02h complete %0b ovf %0b",
                                 $realtime, got.value, got.complete, got.ovf);
                    n_err++;
                end else begin
                    want = read_expect_q.pop_front();
                    if (got !== want) begin
                        if (n_err < MAX_REPORTS)
                            $display("%0t: read %0d expected %02h/%0b/%0b got %02h/%0b/%0b",
                                     $realtime, n_checked, want.value, want.complete,
                                     want.ovf, got.value, got.complete, got.ovf);
                        n_err++;
                    end
                    n_checked++;
                end
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end else if (n_checked >= next_hold_at) begin
                // long hold-off: the sender keeps offering items meanwhile
                i_stall <= 1'b1;
                hold_left <= HOLD_LEN - 1;
                next_hold_at <= n_checked + 400;
                n_holds++;
            end else begin
                i_stall <= !no_gaps && ($urandom_range(0, 99) < GAP_PCT);
            end
        end
    end

    // Watchdog: end the run when nothing moves on any port for too long.
    int quiet_cycles = 0;

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout after %0d idle cycles, %0d reads outstanding",
                     quiet_cycles, read_expect_q.size());
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: a directed layer at reset settings, then random layers under
    // several register settings, extremes included.
    // ------------------------------------------------------------------
    initial begin : stimulus
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        queue_cmd(OP_START, '0, '0);
        queue_cmd(OP_PUSH, 8'd0, '0);
        // read while the layer is still filling
        queue_cmd(OP_READ, '0, '0);
        // zero-length run writes nothing
        queue_cmd(OP_PUSH, 8'd128, '0);
        queue_cmd(OP_PUSH, 8'd127, '0);
        // longest runs, the last one cut at the end of the layer
        repeat (19) queue_cmd(OP_PUSH, 8'd255, ADDR_W'(TILES - 1));
        // full layer drops the push; op 3 is ignored
        queue_cmd(OP_PUSH, 8'd42, '0);
        queue_cmd(OP_UNUSED, 8'hff, 12'hfff);
        queue_cmd(OP_READ, '0, '0);
        queue_cmd(OP_READ, '0, ADDR_W'(TILES - 1));
        // past the end of the store
        queue_cmd(OP_READ, 8'hff, 12'hfff);
        wait_quiet();

        run_phase(1'b1, 1'b1, 7'd0,   260, 1'b0);
        run_phase(1'b0, 1'b0, 7'd127, 260, 1'b0);
        run_phase(1'b1, 1'b0, 7'd35,  220, 1'b1);
        run_phase(1'b0, 1'b1, 7'd127, 260, 1'b0);
        run_phase(1'($urandom_range(0, 1)), 1'b1, LIT_W'($urandom_range(0, 127)), 260, 1'b0);
        run_phase(1'b0, 1'b1, SEED_RESET, 260, 1'b0);

        $display("summary: %0d items taken, %0d tile reads compared, %0d layers decoded",
                 n_taken, n_checked, n_layers);
        $display("summary: %0d of those layers overflowed, %0d register settings, %0d hold-offs",
                 n_ovf_layers, n_settings, n_holds);
        if (n_err == 0 && read_expect_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches", n_err);
            $display("tb: failure");
        end
        $finish;
    end

endmodule
